// ===== rtl/pmm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmm_pkg: shared types and constants of the partitioned matrix multiplier
// Field widths, register codes, sequencer states and the MAC control word.
// ----------------------------------------------------------------------------
package pmm_pkg;

    localparam int MAX_N_DEF  = 8;

    localparam int FUNC_W     = 2;
    localparam int ROW_W      = 3;
    localparam int COL_W      = 3;
    localparam int VAL_W      = 16;
    localparam int SUM_W      = 32;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int SIZE_W     = 4;
    localparam int WIDX_W     = 6;
    localparam int WCNT_W     = 7;

    localparam logic [SIZE_W-1:0] SIZE_RST = 4'd8;
    localparam logic [WIDX_W-1:0] WIDX_RST = 6'd0;
    localparam logic [WCNT_W-1:0] WCNT_RST = 7'd1;
    localparam logic              INTL_RST = 1'b1;

    typedef enum logic [FUNC_W-1:0] {
        FN_LEFT    = 2'd0,
        FN_RIGHT   = 2'd1,
        FN_COMPUTE = 2'd2
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIZE = 2'd0,
        CFG_WIDX = 2'd1,
        CFG_WCNT = 2'd2,
        CFG_INTL = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIV,
        ST_BOUND,
        ST_SCAN,
        ST_ISSUE,
        ST_WAIT,
        ST_PUSH
    } t_state;

    // One term of a dot product entering the MAC pipeline
    typedef struct packed {
        logic vld;
        logic first;
        logic last;
    } t_mac_ctl;

endpackage
`default_nettype wire

// ===== rtl/pmm_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmm_mem: matrix element store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pmm_mem
    import pmm_pkg::*;
#(
    parameter int DEPTH = MAX_N_DEF * MAX_N_DEF,
    parameter int AW    = $clog2(MAX_N_DEF * MAX_N_DEF)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [VAL_W-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [VAL_W-1:0] o_rdata
);

    logic [VAL_W-1:0] r_mem [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/pmm_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmm_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pmm_div
    import pmm_pkg::*;
#(
    parameter int W = 7
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [W-1:0] i_dividend,
    input  wire logic [W-1:0] i_divisor,
    output logic              o_done,
    output logic      [W-1:0] o_quot
);

    localparam int CNTW = $clog2(W + 1);

    logic            r_busy;
    logic            r_done;
    logic [CNTW-1:0] r_cnt;
    logic [W:0]      r_rem;
    logic [W-1:0]    r_quo;
    logic [W-1:0]    r_dvs;
    logic [W:0]      w_sh;
    logic            w_ge;

    // shift in the next dividend bit, then try a subtract
    assign w_sh = {r_rem[W-1:0], r_quo[W-1]};
    assign w_ge = (w_sh >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNTW'(1);
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? (w_sh - {1'b0, r_dvs}) : w_sh;
            r_quo <= {r_quo[W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule
`default_nettype wire

// ===== rtl/pmm_mac.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmm_mac: shared multiply-accumulate unit
// Control enters with the read address; operands arrive in the following cycle.
// ----------------------------------------------------------------------------
module pmm_mac
    import pmm_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_mac_ctl         i_ctl,
    input  wire logic [VAL_W-1:0] i_a,
    input  wire logic [VAL_W-1:0] i_b,
    output logic      [SUM_W-1:0] o_sum,
    output logic                  o_done
);

    t_mac_ctl                   r_c1;
    t_mac_ctl                   r_c2;
    logic                       r_done;
    logic signed [2*VAL_W-1:0]  w_prod;
    logic        [2*VAL_W-1:0]  r_prod;
    logic        [SUM_W-1:0]    r_acc;

    assign w_prod = $signed(i_a) * $signed(i_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1   <= '0;
            r_c2   <= '0;
            r_done <= 1'b0;
        end else begin
            r_c1   <= i_ctl;
            r_c2   <= r_c1;
            r_done <= r_c2.vld & r_c2.last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        if (r_c2.vld) begin
            r_acc <= (r_c2.first ? '0 : r_acc) + SUM_W'(r_prod);
        end
    end

    assign o_sum  = r_acc;
    assign o_done = r_done;

endmodule
`default_nettype wire

// ===== rtl/partitioned_matrix_multiply.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// partitioned_matrix_multiply: one worker's share of an integer matrix product
// Loads two n x n matrices of 16-bit elements, then emits the product cells
// assigned to this worker, strided or as a contiguous block.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                    payload
//  --------  ---------  ---------------------------  ------------------------------
//  in        input      i_in_valid / o_in_ready      i_func i_row i_col i_value
//  out       output     o_out_valid / i_out_ready    o_out_row o_out_col o_cell_sum
//                                                    o_last
//  cfg       input      i_cfg_we (no wait)           i_cfg_idx i_cfg_data
//
//  A compute word first passes through setup, the iterative divider that
//  sizes the contiguous block (CW is the width of the cell count) and the
//  bound step, then walks the unowned cell indices before the worker's
//  last cell and runs the dot product of each owned cell through the
//  single shared multiply-accumulate unit.
//  Reset restores the register defaults; matrix contents are not cleared.
//  A result waits in the output register; the sequencer holds before the
//  next push while that register is full and not taken. Input is not ready
//  until the last result of a compute word is pushed.
// ----------------------------------------------------------------------------
module partitioned_matrix_multiply
    import pmm_pkg::*;
#(
    parameter int MAX_N = MAX_N_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [FUNC_W-1:0]     i_func,
    input  wire logic [ROW_W-1:0]      i_row,
    input  wire logic [COL_W-1:0]      i_col,
    input  wire logic [VAL_W-1:0]      i_value,

    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic      [ROW_W-1:0]      o_out_row,
    output logic      [COL_W-1:0]      o_out_col,
    output logic      [SUM_W-1:0]      o_cell_sum,
    output logic                       o_last,

    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int DEPTH = MAX_N * MAX_N;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW    = (MAX_N > 1) ? $clog2(MAX_N) : 1;   // row, column, k
    localparam int NW    = $clog2(MAX_N + 1);                 // n itself
    localparam int CW    = $clog2(DEPTH + 1);                 // cell count
    localparam int NXW   = CW + 1;                            // next owned cell
    localparam int XW    = ((CW > WCNT_W) ? CW : WCNT_W) + 1; // compare width

    // configuration
    logic [SIZE_W-1:0] r_size;
    logic [WIDX_W-1:0] r_widx;
    logic [WCNT_W-1:0] r_wcnt;
    logic              r_intl;

    // sequencer
    t_state            r_state;
    t_state            n_state;
    logic [NW-1:0]     r_n;
    logic [CW-1:0]     r_total;
    logic [CW-1:0]     r_cnt;
    logic [CW-1:0]     r_end;
    logic [CW-1:0]     r_step;
    logic [NXW-1:0]    r_next;
    logic [CW-1:0]     r_idx;
    logic [IW-1:0]     r_i;
    logic [IW-1:0]     r_j;
    logic [IW-1:0]     r_k;
    logic              r_is_last;

    // output register
    logic              r_ov;
    logic [ROW_W-1:0]  r_out_row;
    logic [COL_W-1:0]  r_out_col;
    logic [SUM_W-1:0]  r_out_sum;
    logic              r_out_last;

    logic [NW-1:0]     w_n_use;
    logic [CW-1:0]     w_tot;
    logic [CW-1:0]     w_cnt;
    logic [CW-1:0]     w_base;
    logic [NXW-1:0]    w_prod;
    logic [NXW-1:0]    w_start;
    logic [CW-1:0]     w_end;
    logic [CW-1:0]     w_step;
    logic              w_none;
    logic              w_in_acc;
    logic              w_div_start;
    logic              w_div_done;
    logic              w_owned;
    logic              w_past_end;
    logic              w_j_last;
    logic              w_k_last;
    logic              w_load;
    logic              w_we_l;
    logic              w_we_r;
    logic [AW-1:0]     w_waddr;
    logic [AW-1:0]     w_laddr;
    logic [AW-1:0]     w_raddr;
    logic [VAL_W-1:0]  w_ldata;
    logic [VAL_W-1:0]  w_rdata;
    t_mac_ctl          w_mac_ctl;
    logic [SUM_W-1:0]  w_mac_sum;
    logic              w_mac_done;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_RST;
            r_widx <= WIDX_RST;
            r_wcnt <= WCNT_RST;
            r_intl <= INTL_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SIZE: r_size <= i_cfg_data[SIZE_W-1:0];
                CFG_WIDX: r_widx <= i_cfg_data[WIDX_W-1:0];
                CFG_WCNT: r_wcnt <= i_cfg_data[WCNT_W-1:0];
                CFG_INTL: r_intl <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Effective size and worker count: zero becomes one, clamp above
    // ------------------------------------------------------------------
    always_comb begin
        if (r_size == '0) begin
            w_n_use = NW'(1);
        end else if (32'(r_size) > MAX_N) begin
            w_n_use = NW'(MAX_N);
        end else begin
            w_n_use = NW'(r_size);
        end
        w_tot = CW'(32'(w_n_use) * 32'(w_n_use));
        if (r_wcnt == '0) begin
            w_cnt = CW'(1);
        end else if (XW'(r_wcnt) > XW'(w_tot)) begin
            w_cnt = w_tot;
        end else begin
            w_cnt = CW'(r_wcnt);
        end
    end

    // ------------------------------------------------------------------
    // Share bounds: strided from the worker index, or a block of
    // total / count cells with the remainder on the last worker
    // ------------------------------------------------------------------
    assign w_prod = NXW'((WIDX_W + CW)'(r_widx) * (WIDX_W + CW)'(w_base));
    assign w_none = (XW'(r_widx) >= XW'(r_cnt));

    always_comb begin
        if (r_intl) begin
            w_start = NXW'(r_widx);
            w_end   = r_total;
            w_step  = r_cnt;
        end else begin
            w_start = w_prod;
            w_end   = (XW'(r_widx) == (XW'(r_cnt) - XW'(1)))
                      ? r_total : CW'(w_prod + NXW'(w_base));
            w_step  = CW'(1);
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    assign w_in_acc   = i_in_valid & o_in_ready;
    assign w_past_end = (r_idx >= r_end);
    assign w_owned    = (NXW'(r_idx) == r_next);
    assign w_j_last   = ((NW'(r_j) + NW'(1)) == r_n);
    assign w_k_last   = ((NW'(r_k) + NW'(1)) == r_n);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc && (i_func == FN_COMPUTE)) begin
                    n_state = ST_SETUP;
                end
            end
            ST_SETUP: n_state = ST_DIV;
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_BOUND;
                end
            end
            ST_BOUND: n_state = w_none ? ST_IDLE : ST_SCAN;
            ST_SCAN: begin
                priority if (w_past_end) begin
                    n_state = ST_IDLE;
                end else if (w_owned) begin
                    n_state = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (w_k_last) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (w_mac_done) begin
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (w_load) begin
                    n_state = r_is_last ? ST_IDLE : ST_SCAN;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------
    always_comb begin
        o_in_ready      = (r_state == ST_IDLE);
        w_div_start     = (r_state == ST_SETUP);
        w_load          = (r_state == ST_PUSH) && (!r_ov || i_out_ready);
        w_mac_ctl.vld   = (r_state == ST_ISSUE);
        w_mac_ctl.first = (r_k == '0);
        w_mac_ctl.last  = w_k_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer datapath: walk cell indices in row-major order, stop on
    // the next owned cell, run its dot product, push it
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_SETUP: begin
                r_n     <= w_n_use;
                r_total <= w_tot;
                r_cnt   <= w_cnt;
            end
            ST_BOUND: begin
                r_next <= w_start;
                r_end  <= w_end;
                r_step <= w_step;
                r_idx  <= '0;
                r_i    <= '0;
                r_j    <= '0;
            end
            ST_SCAN: begin
                priority if (w_past_end) begin
                end else if (w_owned) begin
                    r_k       <= '0;
                    r_is_last <= ((r_next + NXW'(r_step)) >= NXW'(r_end));
                end else begin
                    r_idx <= r_idx + CW'(1);
                    if (w_j_last) begin
                        r_j <= '0;
                        r_i <= r_i + IW'(1);
                    end else begin
                        r_j <= r_j + IW'(1);
                    end
                end
            end
            ST_ISSUE: r_k <= r_k + IW'(1);
            ST_PUSH: begin
                if (w_load && !r_is_last) begin
                    r_next <= r_next + NXW'(r_step);
                    r_idx  <= r_idx + CW'(1);
                    if (w_j_last) begin
                        r_j <= '0;
                        r_i <= r_i + IW'(1);
                    end else begin
                        r_j <= r_j + IW'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Output register: full flag resets, payload does not
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_load) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_row  <= ROW_W'(r_i);
            r_out_col  <= COL_W'(r_j);
            r_out_sum  <= w_mac_sum;
            r_out_last <= r_is_last;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_row   = r_out_row;
    assign o_out_col   = r_out_col;
    assign o_cell_sum  = r_out_sum;
    assign o_last      = r_out_last;

    // ------------------------------------------------------------------
    // Matrix stores: drop writes outside the built size
    // ------------------------------------------------------------------
    assign w_waddr = AW'(32'(i_row) * MAX_N + 32'(i_col));
    assign w_we_l  = w_in_acc && (i_func == FN_LEFT)
                     && (32'(i_row) < MAX_N) && (32'(i_col) < MAX_N);
    assign w_we_r  = w_in_acc && (i_func == FN_RIGHT)
                     && (32'(i_row) < MAX_N) && (32'(i_col) < MAX_N);
    assign w_laddr = AW'(32'(r_i) * MAX_N + 32'(r_k));
    assign w_raddr = AW'(32'(r_k) * MAX_N + 32'(r_j));

    pmm_mem #(
        .DEPTH   (DEPTH),
        .AW      (AW)
    ) u_left (
        .i_clk   (i_clk),
        .i_we    (w_we_l),
        .i_waddr (w_waddr),
        .i_wdata (i_value),
        .i_raddr (w_laddr),
        .o_rdata (w_ldata)
    );

    pmm_mem #(
        .DEPTH   (DEPTH),
        .AW      (AW)
    ) u_right (
        .i_clk   (i_clk),
        .i_we    (w_we_r),
        .i_waddr (w_waddr),
        .i_wdata (i_value),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    pmm_div #(
        .W          (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_tot),
        .i_divisor  (w_cnt),
        .o_done     (w_div_done),
        .o_quot     (w_base)
    );

    pmm_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_mac_ctl),
        .i_a     (w_ldata),
        .i_b     (w_rdata),
        .o_sum   (w_mac_sum),
        .o_done  (w_mac_done)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_mac_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mac_done |-> (r_state == ST_WAIT))
        else $error("dot product finished outside the wait state");

    a_scan_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (NXW'(r_idx) <= r_next))
        else $error("cell walk passed the next owned cell");

    a_issue_k: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ISSUE) |-> (NW'(r_k) < r_n))
        else $error("dot product term beyond matrix size");

    a_compute_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_func == FN_COMPUTE)) |=> (r_state == ST_SETUP))
        else $error("compute word did not start the sequencer");

endmodule
`default_nettype wire

// ===== dv/partitioned_matrix_multiply_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// partitioned_matrix_multiply_tb: self-checking bench for the worker-share
// matrix multiplier
// Loads both matrices through the input channel, issues compute words under
// many register settings and checks every emitted product cell against a
// predictor that tracks matrix contents on each accepted word and the registers on each write.
// ----------------------------------------------------------------------------
module partitioned_matrix_multiply_tb;
    import pmm_pkg::*;

    localparam int DIM             = MAX_N_DEF;
    localparam int CELLS           = DIM * DIM;
    localparam int WORD_TARGET     = 280;
    localparam int SETTLE_CYCLES   = 100;     // covers the setup of a silent compute
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RUN_LIMIT_NS    = 20_000_000;

    // Func code 3 has no meaning; the block drops such a word
    localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

    typedef struct {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [SUM_W-1:0] sum;
        logic             last;
    } t_product_cell;

    // ------------------------------------------------------------------------
    // Scoreboard: mirrors matrices and registers, queues the product cells
    // each compute word must emit, and checks cells in order of arrival.
    // ------------------------------------------------------------------------
    class cell_scoreboard;
        logic signed [VAL_W-1:0] left_m[CELLS];
        logic signed [VAL_W-1:0] right_m[CELLS];
        bit                      left_set[CELLS];
        bit                      right_set[CELLS];
        logic [SIZE_W-1:0]       size_reg;
        logic [WIDX_W-1:0]       widx_reg;
        logic [WCNT_W-1:0]       wcnt_reg;
        logic                    intl_reg;
        t_product_cell           pending_cells[$];
        int                      errors;
        int                      cells_checked;
        int                      loads;
        int                      computes;

        function new();
            size_reg      = SIZE_RST;
            widx_reg      = WIDX_RST;
            wcnt_reg      = WCNT_RST;
            intl_reg      = INTL_RST;
            errors        = 0;
            cells_checked = 0;
            loads         = 0;
            computes      = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_SIZE: size_reg = data[SIZE_W-1:0];
                CFG_WIDX: widx_reg = data[WIDX_W-1:0];
                CFG_WCNT: wcnt_reg = data[WCNT_W-1:0];
                CFG_INTL: intl_reg = data[0];
                default: ;
            endcase
        endfunction

        // Dimension after saturation: zero acts as one, above DIM acts as DIM
        function int active_n();
            int n;
            n = int'(size_reg);
            if (n == 0) n = 1;
            if (n > DIM) n = DIM;
            return n;
        endfunction

        function logic [SUM_W-1:0] dot(int n, int i, int j);
            logic signed [SUM_W-1:0] acc;
            logic signed [SUM_W-1:0] prod;
            int                      k;
            acc = '0;
            for (k = 0; k < n; k++) begin
                prod = SUM_W'(left_m[i * DIM + k]) * SUM_W'(right_m[k * DIM + j]);
                acc  = acc + prod;
            end
            return acc;
        endfunction

        // Queue the cells of this worker's share in ascending row-major order
        function void queue_share();
            t_product_cell pcell;
            int            n, total, cnt, widx, base, first, stop, step, p;
            n     = active_n();
            total = n * n;
            cnt   = int'(wcnt_reg);
            widx  = int'(widx_reg);
            if (cnt == 0) cnt = 1;
            if (cnt > total) cnt = total;
            if (widx >= cnt) return;
            if (intl_reg) begin
                first = widx;
                stop  = total;
                step  = cnt;
            end else begin
                base  = total / cnt;
                first = widx * base;
                stop  = (widx == cnt - 1) ? total : first + base;
                step  = 1;
            end
            for (p = first; p < stop; p += step) begin
                pcell.row  = ROW_W'(p / n);
                pcell.col  = COL_W'(p % n);
                pcell.sum  = dot(n, p / n, p % n);
                pcell.last = (p + step >= stop);
                pending_cells.push_back(pcell);
            end
        endfunction

        function void note_word(logic [FUNC_W-1:0] fn, logic [ROW_W-1:0] r,
                                logic [COL_W-1:0] c, logic [VAL_W-1:0] v);
            case (fn)
                FN_LEFT: begin
                    left_m[r * DIM + c]   = v;
                    left_set[r * DIM + c] = 1'b1;
                    loads++;
                end
                FN_RIGHT: begin
                    right_m[r * DIM + c]   = v;
                    right_set[r * DIM + c] = 1'b1;
                    loads++;
                end
                FN_COMPUTE: begin
                    computes++;
                    queue_share();
                end
                default: ;
            endcase
        endfunction

        function void report(string field, logic [SUM_W-1:0] want, logic [SUM_W-1:0] got);
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
            errors++;
        endfunction

        function void check_cell(logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                                 logic [SUM_W-1:0] sum, logic last);
            t_product_cell want;
            if (pending_cells.size() == 0) begin
                $display("%0t: unexpected product cell (%0d,%0d), expected none, got 0x%0h",
                         $time, row, col, sum);
                errors++;
                return;
            end
            want = pending_cells.pop_front();
            cells_checked++;
            if (row !== want.row)   report("out_row", SUM_W'(want.row), SUM_W'(row));
            if (col !== want.col)   report("out_col", SUM_W'(want.col), SUM_W'(col));
            if (sum !== want.sum)   report("cell_sum", want.sum, sum);
            if (last !== want.last) report("last", SUM_W'(want.last), SUM_W'(last));
        endfunction

        function int outstanding();
            return pending_cells.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [FUNC_W-1:0]     i_func;
    logic [ROW_W-1:0]      i_row;
    logic [COL_W-1:0]      i_col;
    logic [VAL_W-1:0]      i_value;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [ROW_W-1:0]      o_out_row;
    logic [COL_W-1:0]      o_out_col;
    logic [SUM_W-1:0]      o_cell_sum;
    logic                  o_last;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    cell_scoreboard sb = new();

    int words_sent;         // accepted words the block acts on
    int settings_used;
    bit quiet_mode;         // no idle cycles on either side while set
    bit hold_off_pending;   // ask the receiver for one long stall

    partitioned_matrix_multiply DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_func      (i_func),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_cell_sum  (o_cell_sum),
        .o_last      (o_last),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Check every product cell taken at a rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_cell(o_out_row, o_out_col, o_cell_sum, o_last);
    end

    // Receiver: draw a stall per cell, honor one long hold-off on request
    initial begin
        int stall;
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (hold_off_pending) begin
                hold_off_pending = 1'b0;
                stall            = HOLD_OFF_CYCLES;
            end else begin
                stall = quiet_mode ? 0 : $urandom_range(0, 8);
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!(o_out_valid && i_out_ready)) @(posedge i_clk);
        end
    end

    // Bound the run in case the block hangs
    initial begin
        #(RUN_LIMIT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Element values lean on the sign extremes so sums wrap often
    function automatic logic [VAL_W-1:0] rand_value();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'hFFFF;
            3: return 16'h0000;
            default: return VAL_W'($urandom);
        endcase
    endfunction

    // Offer one word and hold it until taken. Valid stays high after the
    // handshake so a back-to-back word needs no drop in the same step.
    task automatic send_word(logic [FUNC_W-1:0] fn, logic [ROW_W-1:0] r,
                             logic [COL_W-1:0] c, logic [VAL_W-1:0] v);
        int gap;
        gap = quiet_mode ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func     <= fn;
        i_row      <= r;
        i_col      <= c;
        i_value    <= v;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_word(fn, r, c, v);
        if (fn != FN_UNUSED) words_sent++;
    endtask

    task automatic load_element(bit to_right, int r, int c, logic [VAL_W-1:0] v);
        send_word(to_right ? FN_RIGHT : FN_LEFT, ROW_W'(r), COL_W'(c), v);
    endtask

    // Fill any element the product will read before issuing the compute
    task automatic start_compute();
        int n, i, k;
        n = sb.active_n();
        for (i = 0; i < n; i++) begin
            for (k = 0; k < n; k++) begin
                if (!sb.left_set[i * DIM + k])  load_element(1'b0, i, k, rand_value());
                if (!sb.right_set[i * DIM + k]) load_element(1'b1, i, k, rand_value());
            end
        end
        send_word(FN_COMPUTE, ROW_W'($urandom), COL_W'($urandom), VAL_W'($urandom));
    endtask

    // Drop valid, drain the expected cells, then let a silent compute finish
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (sb.outstanding() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(logic [SIZE_W-1:0] size, logic [WIDX_W-1:0] widx,
                             logic [WCNT_W-1:0] wcnt, logic intl);
        logic [CFG_DATA_W-1:0] data[4];
        t_cfg_idx              idx;
        int                    r;
        data[CFG_SIZE] = CFG_DATA_W'(size);
        data[CFG_WIDX] = CFG_DATA_W'(widx);
        data[CFG_WCNT] = CFG_DATA_W'(wcnt);
        data[CFG_INTL] = CFG_DATA_W'(intl);
        for (r = 0; r < 4; r++) begin
            idx = t_cfg_idx'(r);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx;
            i_cfg_data <= data[r];
            @(posedge i_clk);
            sb.write_reg(idx, data[r]);
        end
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    // One register setting followed by a mix of loads, computes and junk
    task automatic run_phase(logic [SIZE_W-1:0] size, logic [WIDX_W-1:0] widx,
                             logic [WCNT_W-1:0] wcnt, logic intl, int n_words,
                             bit steady, bit squeeze);
        int pick;
        wait_idle();
        configure(size, widx, wcnt, intl);
        quiet_mode = steady;
        if (squeeze) begin
            // stall the receiver early so the next word backs up at the input
            hold_off_pending = 1'b1;
            start_compute();
        end
        repeat (n_words) begin
            pick = $urandom_range(0, 99);
            if (pick < 12)
                start_compute();
            else if (pick < 16)
                send_word(FN_UNUSED, ROW_W'($urandom), COL_W'($urandom), VAL_W'($urandom));
            else
                load_element(1'($urandom_range(0, 1)), $urandom_range(0, DIM - 1),
                             $urandom_range(0, DIM - 1), rand_value());
        end
        start_compute();
    endtask

    task automatic run_random_phase();
        logic [SIZE_W-1:0] size;
        logic [WCNT_W-1:0] wcnt;
        logic [WIDX_W-1:0] widx;
        int                n, cnt;
        size = ($urandom_range(0, 3) == 0) ? SIZE_W'($urandom_range(0, 15))
                                           : SIZE_W'($urandom_range(1, 4));
        wcnt = $urandom_range(0, 1) ? WCNT_W'($urandom_range(1, 6))
                                    : WCNT_W'($urandom_range(0, 127));
        n    = (size == 0) ? 1 : ((int'(size) > DIM) ? DIM : int'(size));
        cnt  = (wcnt == 0) ? 1 : ((int'(wcnt) > n * n) ? n * n : int'(wcnt));
        // mostly a worker that owns cells, sometimes any index up to 63
        widx = ($urandom_range(0, 3) != 0) ? WIDX_W'($urandom_range(0, cnt - 1))
                                           : WIDX_W'($urandom_range(0, 63));
        run_phase(size, widx, wcnt, 1'($urandom_range(0, 1)), $urandom_range(6, 16),
                  $urandom_range(0, 3) == 0, 1'b0);
    endtask

    initial begin
        i_rst_n          <= 1'b0;
        i_in_valid       <= 1'b0;
        i_func           <= FN_LEFT;
        i_row            <= '0;
        i_col            <= '0;
        i_value          <= '0;
        i_cfg_we         <= 1'b0;
        i_cfg_idx        <= CFG_SIZE;
        i_cfg_data       <= '0;
        words_sent       = 0;
        settings_used    = 0;
        quiet_mode       = 1'b0;
        hold_off_pending = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: 2x2 with most-negative elements, so each sum wraps to -2^31
        configure(4'd2, 6'd0, 7'd1, 1'b1);
        for (int e = 0; e < 4; e++) load_element(1'b0, e / 2, e % 2, 16'h8000);
        for (int e = 0; e < 4; e++) load_element(1'b1, e / 2, e % 2, 16'h8000);
        start_compute();
        // junk func code, every field at its top
        send_word(FN_UNUSED, 3'd7, 3'd7, 16'hFFFF);
        // mixed extremes, plus writes to the far corner outside the used square
        load_element(1'b0, 0, 0, 16'h7FFF);
        load_element(1'b1, 1, 1, 16'h7FFF);
        load_element(1'b0, 7, 7, 16'h7FFF);
        load_element(1'b1, 7, 7, 16'h0000);
        start_compute();
        load_element(1'b0, 1, 0, 16'h0000);
        load_element(1'b1, 0, 1, 16'h0001);
        start_compute();

        // Register extremes: size and count of zero act as one
        run_phase(4'd0, 6'd0, 7'd0, 1'b1, 6, 1'b1, 1'b0);
        // size saturates to DIM, count clamps to DIM*DIM, last worker owns one cell
        run_phase(4'd15, 6'd63, 7'd127, 1'b0, 8, 1'b0, 1'b0);
        // whole product from one worker while the receiver holds off
        run_phase(4'd8, 6'd0, 7'd1, 1'b0, 8, 1'b0, 1'b1);
        // index past the count: compute words emit nothing
        run_phase(4'd3, 6'd5, 7'd2, 1'b1, 6, 1'b0, 1'b0);
        // contiguous split with a remainder taken by the last worker
        run_phase(4'd5, 6'd6, 7'd7, 1'b0, 6, 1'b0, 1'b0);
        // strided with a wide stride
        run_phase(4'd8, 6'd5, 7'd64, 1'b1, 6, 1'b1, 1'b0);

        while (words_sent < WORD_TARGET) run_random_phase();

        wait_idle();
        $display("Covered %0d load words and %0d compute words under %0d register settings;",
                 sb.loads, sb.computes, settings_used);
        $display("%0d product cells checked.", sb.cells_checked);
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
